// File: rtl/rrk_pkg.sv
// Package for the rainbow reduction block: shared types and register codes.
// No dependencies; every other file imports it.
package rrk_pkg;

  localparam int unsigned AddrW = 4;

  typedef enum logic [1:0] {
    REG_CHARSET = 2'd0,
    REG_LEN_MIN = 2'd1,
    REG_LEN_MAX = 2'd2,
    REG_OFFSET  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [8:0] charset_size;
    logic [3:0] len_min;
    logic [3:0] len_max;
  } cfg_t;

  typedef struct packed {
    logic [63:0] idx;
    logic        err;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [63:0] rem;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MOD  = 5'b00010,
    ST_LEN  = 5'b00100,
    ST_DIG  = 5'b01000,
    ST_OUT  = 5'b10000
  } back_st_e;

endpackage

// File: rtl/rrk_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on rrk_pkg.
module rrk_div import rrk_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [63:0] q_q, r_q, d_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [64:0] trial;
  logic        fits;

  assign trial = {r_q, q_q[63]};
  assign fits  = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      q_q <= req_i.dividend;
      r_q <= '0;
      d_q <= req_i.divisor;
    end else if (busy_q) begin
      // shift in next dividend bit, subtract when it fits
      r_q <= fits ? 64'(trial - {1'b0, d_q}) : trial[63:0];
      q_q <= {q_q[62:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = q_q;
  assign rsp_o.rem  = r_q;

endmodule

// File: rtl/rrk_queue.sv
// Two-entry queue between the front and the back part.
// Depends on rrk_pkg.
module rrk_queue import rrk_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  item_t wr_data_i,
  output logic  full_o,
  input  logic  rd_i,
  output logic  empty_o,
  output item_t rd_data_o
);

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o    = cnt_q == 2'd2;
  assign empty_o   = cnt_q == 2'd0;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= ~wp_q;
      if (rd_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr_i) - 2'(rd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wr_data_i;
  end

endmodule

// File: rtl/rrk_front.sv
// Front part: configuration registers, key-space table build, index sum.
// Depends on rrk_pkg.
module rrk_front import rrk_pkg::*; #(
  parameter int unsigned MaxKeyLen = 8,
  localparam int unsigned IdxW = $clog2(MaxKeyLen + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  input  logic [63:0]      hash_word_i,
  input  logic [31:0]      chain_position_i,
  output item_t            item_o,
  output logic             hold_o,
  output cfg_t             cfg_o,
  output logic [63:0]      prefix_o [MaxKeyLen+1]
);

  logic [8:0]  cs_q;
  logic [3:0]  min_q, max_q;
  logic [31:0] off_q;
  logic        bld_start_q, bld_busy_q, ovf_q;
  logic [3:0]  len_q;
  logic [63:0] cnt_q, prev_q;
  logic [63:0] prefix_q [MaxKeyLen+1];
  logic        wr_en, bad_cfg;
  logic [72:0] prod;
  logic [64:0] sum;
  reg_idx_e    ridx;

  assign ridx  = reg_idx_e'(paddr[3:2]);
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    case (ridx)
      REG_CHARSET: prdata = {23'd0, cs_q};
      REG_LEN_MIN: prdata = {28'd0, min_q};
      REG_LEN_MAX: prdata = {28'd0, max_q};
      REG_OFFSET:  prdata = off_q;
      default:     prdata = '0;
    endcase
  end

  assign bad_cfg = (cs_q == 9'd0) || (cs_q > 9'd256) ||
                   (min_q == 4'd0) || (min_q > 4'(MaxKeyLen)) ||
                   (max_q == 4'd0) || (max_q > 4'(MaxKeyLen)) || (min_q > max_q);
  assign prod = cnt_q * cs_q;
  assign sum  = {1'b0, prev_q} + {1'b0, prod[63:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q        <= 9'd64;
      min_q       <= 4'd1;
      max_q       <= 4'd6;
      off_q       <= '0;
      bld_start_q <= 1'b1;
      bld_busy_q  <= 1'b0;
      ovf_q       <= 1'b0;
      len_q       <= '0;
      cnt_q       <= '0;
      prev_q      <= '0;
      for (int i = 0; i <= MaxKeyLen; i++) prefix_q[i] <= '0;
    end else begin
      if (wr_en) begin
        bld_start_q <= 1'b1;
        case (ridx)
          REG_CHARSET: cs_q  <= pwdata[8:0];
          REG_LEN_MIN: min_q <= pwdata[3:0];
          REG_LEN_MAX: max_q <= pwdata[3:0];
          REG_OFFSET:  off_q <= pwdata;
          default:     bld_start_q <= 1'b0;
        endcase
      end
      if (bld_start_q) begin
        bld_start_q <= 1'b0;
        for (int i = 0; i <= MaxKeyLen; i++) prefix_q[i] <= '0;
        ovf_q      <= bad_cfg;
        bld_busy_q <= ~bad_cfg;
        cnt_q      <= 64'd1;
        prev_q     <= '0;
        len_q      <= 4'd1;
      end else if (bld_busy_q) begin
        // one length per cycle; drop the whole table on overflow
        if (prod[72:64] != '0 || (len_q >= min_q && sum[64])) begin
          ovf_q      <= 1'b1;
          bld_busy_q <= 1'b0;
          for (int i = 0; i <= MaxKeyLen; i++) prefix_q[i] <= '0;
        end else begin
          cnt_q <= prod[63:0];
          if (len_q >= min_q) begin
            prefix_q[IdxW'(len_q)] <= sum[63:0];
            prev_q                 <= sum[63:0];
          end
          if (len_q == max_q) bld_busy_q <= 1'b0;
          len_q <= len_q + 4'd1;
        end
      end
    end
  end

  assign hold_o     = bld_start_q | bld_busy_q;
  assign item_o.idx = hash_word_i + {32'd0, off_q} + {32'd0, chain_position_i};
  assign item_o.err = ovf_q;
  assign cfg_o.charset_size = cs_q;
  assign cfg_o.len_min      = min_q;
  assign cfg_o.len_max      = max_q;
  assign prefix_o = prefix_q;

endmodule

// File: rtl/rrk_back.sv
// Back part: modulo, length search, digit extraction, result register.
// Depends on rrk_pkg and rrk_div.
module rrk_back import rrk_pkg::*; #(
  parameter int unsigned MaxKeyLen = 8,
  localparam int unsigned IdxW = $clog2(MaxKeyLen + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic [63:0] prefix_i [MaxKeyLen+1],
  input  logic        q_empty_i,
  input  item_t       q_data_i,
  output logic        q_rd_o,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [63:0] key_digits_o,
  output logic [3:0]  key_length_o,
  output logic        config_error_o
);

  back_st_e    st_q;
  logic [63:0] idx_q, digits_q, pval;
  logic [3:0]  i_q, len_q;
  logic        err_q, ovalid_q;
  logic [IdxW-1:0] raddr;
  div_req_t    dreq;
  div_rsp_t    drsp;

  rrk_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign raddr = (st_q == ST_IDLE) ? IdxW'(cfg_i.len_max) : IdxW'(i_q - 4'd1);
  assign pval  = prefix_i[raddr];

  always_comb begin
    q_rd_o        = 1'b0;
    dreq.start    = 1'b0;
    dreq.dividend = idx_q;
    dreq.divisor  = {55'd0, cfg_i.charset_size};
    unique case (st_q)
      ST_IDLE: begin
        q_rd_o = ~q_empty_i;
        if (~q_empty_i && ~q_data_i.err) begin
          dreq.start    = 1'b1;
          dreq.dividend = q_data_i.idx;
          dreq.divisor  = pval;
        end
      end
      ST_LEN: begin
        if (idx_q >= pval) begin
          dreq.start    = 1'b1;
          dreq.dividend = idx_q - pval;
        end
      end
      ST_DIG: begin
        if (drsp.done && i_q != 4'd1) begin
          dreq.start    = 1'b1;
          dreq.dividend = drsp.quot;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      if (pop_i && ovalid_q) ovalid_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: if (~q_empty_i) st_q <= q_data_i.err ? ST_OUT : ST_MOD;
        ST_MOD:  if (drsp.done) st_q <= ST_LEN;
        ST_LEN:  if (idx_q >= pval) st_q <= ST_DIG;
        ST_DIG:  if (drsp.done && i_q == 4'd1) st_q <= ST_OUT;
        ST_OUT: begin
          if (!ovalid_q) begin
            ovalid_q <= 1'b1;
            st_q     <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        err_q    <= q_data_i.err;
        digits_q <= '0;
        len_q    <= '0;
      end
      ST_MOD: begin
        idx_q <= drsp.rem;
        i_q   <= cfg_i.len_max;
      end
      ST_LEN: begin
        // entries below the minimum length read as zero, so the scan stops there
        if (idx_q >= pval) len_q <= i_q;
        else i_q <= i_q - 4'd1;
      end
      ST_DIG: begin
        if (drsp.done) begin
          digits_q[8*(3'(i_q - 4'd1)) +: 8] <= drsp.rem[7:0];
          i_q <= i_q - 4'd1;
        end
      end
      ST_OUT: begin
        if (!ovalid_q) begin
          key_digits_o   <= digits_q;
          key_length_o   <= len_q;
          config_error_o <= err_q;
        end
      end
      default: ;
    endcase
  end

  assign empty_o = ~ovalid_q;

endmodule

// File: rtl/rainbow_reduction_to_key_core.sv
// Rainbow-table reduction core: hash word plus chain position to key digits.
// Steps: the item passes the queue, the key-space modulo runs through the shared radix-2
// divider, a length search probes the table, then each digit takes one more division
// through the same divider before the output register takes the result.
// Throughput: one item at a time in the back part; the two-entry queue buffers two more.
// Reset: registers return to 64/1/6/0 and the key-space table rebuilds, during which
// full stays high; the same rebuild follows every register write.
module rainbow_reduction_to_key_core import rrk_pkg::*; #(
  parameter int unsigned MaxKeyLen = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input items
  input  logic             push,
  output logic             full,
  input  logic [63:0]      hash_word_i,
  input  logic [31:0]      chain_position_i,
  // result items
  output logic             empty,
  input  logic             pop,
  output logic [63:0]      key_digits_o,
  output logic [3:0]       key_length_o,
  output logic             config_error_o
);

  item_t       f_item, q_item;
  logic        f_hold, q_full, q_empty, q_rd, q_wr;
  cfg_t        cfg;
  logic [63:0] prefix [MaxKeyLen+1];

  assign pready = 1'b1;
  // hold off items while the key-space table is rebuilt
  assign full = f_hold | q_full;
  assign q_wr = push & ~full;

  rrk_front #(.MaxKeyLen(MaxKeyLen)) u_front (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .hash_word_i, .chain_position_i,
    .item_o(f_item), .hold_o(f_hold), .cfg_o(cfg), .prefix_o(prefix)
  );

  rrk_queue u_queue (
    .clk_i, .rst_ni, .wr_i(q_wr), .wr_data_i(f_item), .full_o(q_full),
    .rd_i(q_rd), .empty_o(q_empty), .rd_data_o(q_item)
  );

  rrk_back #(.MaxKeyLen(MaxKeyLen)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .prefix_i(prefix),
    .q_empty_i(q_empty), .q_data_i(q_item), .q_rd_o(q_rd),
    .empty_o(empty), .pop_i(pop),
    .key_digits_o, .key_length_o, .config_error_o
  );

endmodule
